>>> rtl/ptl_pkg.sv
// Package for the particle time-step limiter: fixed-point constants, state
// enums and the request/response structs between the sequencer and the shared
// divide/square-root unit. No dependencies.
`default_nettype none

package ptl_pkg;

    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned WORD_W    = 32;
    // dividend for the acceleration limit: 2 * w * 2^(2F)
    localparam int unsigned DVD_W     = WORD_W + 1 + 2 * FRAC_BITS;
    localparam int unsigned QUO_W     = 2 * WORD_W;
    localparam int unsigned CNT_W     = $clog2(DVD_W + 1);
    localparam int unsigned VEL_STEPS = WORD_W + FRAC_BITS;
    localparam int unsigned ACC_STEPS = DVD_W;
    localparam int unsigned SQRT_STEPS = QUO_W / 2;

    localparam logic [WORD_W-1:0] MAXCODE = '1;
    localparam logic [WORD_W-1:0] ONE_FX  = WORD_W'(1) << FRAC_BITS;

    localparam logic [1:0] REG_CELL_X    = 2'd0;
    localparam logic [1:0] REG_CELL_Y    = 2'd1;
    localparam logic [1:0] REG_CELL_Z    = 2'd2;
    localparam logic [1:0] REG_STABILITY = 2'd3;

    // limiter order: {axis, is_accel}; last one is z acceleration
    localparam logic [2:0] IDX_LAST = 3'd5;

    typedef enum logic [1:0] {
        U_IDLE,
        U_DIV,
        U_SQRT
    } t_unit_state;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_MUL,
        S_OUT
    } t_seq_state;

    typedef struct packed {
        logic              start;
        logic              acc;
        logic [WORD_W-1:0] width;
        logic [WORD_W-1:0] mag;
    } t_unit_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] limit;
    } t_unit_rsp;

endpackage

`default_nettype wire

>>> rtl/ptl_divsqrt.sv
// Shared iterative unit: restoring divider (one quotient bit per cycle) and
// digit-by-digit square root (one root bit per cycle). Depends on ptl_pkg.
`default_nettype none

module ptl_divsqrt (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ptl_pkg::t_unit_req  i_req,
    output ptl_pkg::t_unit_rsp  o_rsp
);

    ptl_pkg::t_unit_state r_state, n_state;

    logic                         r_acc;
    logic [ptl_pkg::WORD_W-1:0]   r_mag;
    logic [ptl_pkg::DVD_W-1:0]    r_dvd;
    logic [ptl_pkg::WORD_W-1:0]   r_rem;
    logic [ptl_pkg::QUO_W-1:0]    r_q;
    logic                         r_ovf;
    logic [ptl_pkg::CNT_W-1:0]    r_cnt;
    logic [ptl_pkg::WORD_W-1:0]   r_root;
    logic [ptl_pkg::WORD_W+1:0]   r_srem;
    logic                         r_done;
    logic [ptl_pkg::WORD_W-1:0]   r_limit;

    logic [ptl_pkg::WORD_W:0]     rem_sh;
    logic [ptl_pkg::WORD_W:0]     rem_diff;
    logic                         div_ge;
    logic [ptl_pkg::QUO_W-1:0]    q_next;
    logic                         ovf_next;
    logic                         last_step;
    logic [ptl_pkg::WORD_W+3:0]   srem_sh;
    logic [ptl_pkg::WORD_W+3:0]   trial;
    logic                         sqrt_ge;
    logic [ptl_pkg::WORD_W-1:0]   root_next;
    logic                         to_sqrt;
    logic                         done_next;

    always_comb begin
        rem_sh    = {r_rem, r_dvd[ptl_pkg::DVD_W-1]};
        rem_diff  = rem_sh - {1'b0, r_mag};
        div_ge    = rem_sh >= {1'b0, r_mag};
        q_next    = {r_q[ptl_pkg::QUO_W-2:0], div_ge};
        ovf_next  = r_ovf | r_q[ptl_pkg::QUO_W-1];
        last_step = r_cnt == ptl_pkg::CNT_W'(1);
        srem_sh   = {r_srem, r_q[ptl_pkg::QUO_W-1:ptl_pkg::QUO_W-2]};
        trial     = {2'b00, r_root, 2'b01};
        sqrt_ge   = srem_sh >= trial;
        root_next = {r_root[ptl_pkg::WORD_W-2:0], sqrt_ge};
        to_sqrt   = (r_state == ptl_pkg::U_DIV) && last_step && r_acc && !ovf_next;
        done_next = ((r_state == ptl_pkg::U_DIV) && last_step && (!r_acc || ovf_next))
                    || ((r_state == ptl_pkg::U_SQRT) && last_step);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptl_pkg::U_IDLE: if (i_req.start) n_state = ptl_pkg::U_DIV;
            ptl_pkg::U_DIV: begin
                if (last_step) begin
                    n_state = (r_acc && !ovf_next) ? ptl_pkg::U_SQRT : ptl_pkg::U_IDLE;
                end
            end
            ptl_pkg::U_SQRT: if (last_step) n_state = ptl_pkg::U_IDLE;
            default: n_state = ptl_pkg::U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptl_pkg::U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= done_next;
            unique case (r_state)
                ptl_pkg::U_IDLE: begin
                    if (i_req.start) begin
                        r_acc <= i_req.acc;
                        r_mag <= i_req.mag;
                        r_dvd <= {i_req.width, (ptl_pkg::DVD_W - ptl_pkg::WORD_W)'(0)};
                        r_rem <= '0;
                        r_q   <= '0;
                        r_ovf <= 1'b0;
                        r_cnt <= i_req.acc ? ptl_pkg::CNT_W'(ptl_pkg::ACC_STEPS)
                                           : ptl_pkg::CNT_W'(ptl_pkg::VEL_STEPS);
                    end
                end
                ptl_pkg::U_DIV: begin
                    r_dvd <= {r_dvd[ptl_pkg::DVD_W-2:0], 1'b0};
                    r_rem <= div_ge ? rem_diff[ptl_pkg::WORD_W-1:0]
                                    : rem_sh[ptl_pkg::WORD_W-1:0];
                    r_q   <= q_next;
                    r_ovf <= ovf_next;
                    // hand the quotient over as radicand
                    r_cnt <= to_sqrt ? ptl_pkg::CNT_W'(ptl_pkg::SQRT_STEPS)
                                     : r_cnt - ptl_pkg::CNT_W'(1);
                    if (last_step) begin
                        if (!r_acc) begin
                            r_limit <= (q_next[ptl_pkg::QUO_W-1:ptl_pkg::WORD_W] != '0)
                                       ? ptl_pkg::MAXCODE : q_next[ptl_pkg::WORD_W-1:0];
                        end else if (ovf_next) begin
                            r_limit <= ptl_pkg::MAXCODE;
                        end else begin
                            r_srem <= '0;
                            r_root <= '0;
                        end
                    end
                end
                ptl_pkg::U_SQRT: begin
                    r_q    <= {r_q[ptl_pkg::QUO_W-3:0], 2'b00};
                    r_srem <= sqrt_ge ? 34'(srem_sh - trial) : 34'(srem_sh);
                    r_root <= root_next;
                    r_cnt  <= r_cnt - ptl_pkg::CNT_W'(1);
                    if (last_step) begin
                        r_limit <= root_next;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_rsp.done  = r_done;
        o_rsp.limit = r_limit;
    end

endmodule

`default_nettype wire

>>> rtl/particle_timestep_limiter.sv
// Top level of the particle time-step limiter: stream ports, config registers,
// limiter sequencer and running minimum. Depends on ptl_pkg and ptl_divsqrt.
//
// Usage: one particle per s_axis transfer (three velocities, then three
// accelerations, signed Q16.16, x lowest in tdata); tlast ends the set.
// Per axis the block forms cell_width/|v| and sqrt(2*cell_width/|a|) on one
// shared divide/sqrt unit, skipping zero components, and keeps the minimum.
// Each velocity limit is a division on the single bit-per-cycle unit, each
// acceleration limit a division and, unless the quotient overflows, a square
// root. s_axis_tready is high only while idle. On a tlast particle the states
// S_MUL and S_OUT form the product stability_factor * minimum and load
// the m_axis register (step size in tdata, unlimited flag in tuser); the
// minimum then returns to all ones. If the receiver stalls with a result still
// held, the next result waits in the sequencer. Config writes are taken at any
// time (o_cfg_ready is tied high) and must only arrive while idle.
// Reset (synchronous, active low) sets the cell widths and stability factor
// to 1.0, the minimum to "no limit" and empties the output register.
`default_nettype none

module particle_timestep_limiter (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // velocity_x, velocity_y, velocity_z, accel_in_x, accel_in_y, accel_in_z
    input  wire  [191:0] s_axis_tdata,
    input  wire          s_axis_tlast,   // last_particle
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // step_size
    output logic [0:0]   m_axis_tuser,   // unlimited
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [1:0]   i_cfg_index,
    input  wire  [31:0]  i_cfg_data
);

    localparam int unsigned W = ptl_pkg::WORD_W;

    ptl_pkg::t_seq_state r_state, n_state;
    ptl_pkg::t_unit_req  w_req;
    ptl_pkg::t_unit_rsp  w_rsp;

    logic [W-1:0]   r_cell [3];
    logic [W-1:0]   r_sf;
    logic [W-1:0]   r_vel [3];
    logic [W-1:0]   r_acc [3];
    logic           r_last;
    logic [2:0]     r_idx;
    logic [W-1:0]   r_min;
    logic [2*W-1:0] r_prod;

    logic [1:0]     axis;
    logic [W-1:0]   raw;
    logic [W-1:0]   mag;
    logic           idx_end;
    logic           out_free;
    logic           unl;
    logic [W-1:0]   prod_sh;
    logic [W-1:0]   step;

    always_comb begin
        axis     = r_idx[2:1];
        raw      = r_idx[0] ? r_acc[axis] : r_vel[axis];
        mag      = raw[W-1] ? (~raw + W'(1)) : raw;
        idx_end  = r_idx == ptl_pkg::IDX_LAST;
        out_free = !m_axis_tvalid || m_axis_tready;
        unl      = r_min == ptl_pkg::MAXCODE;
        prod_sh  = (r_prod[2*W-1:W+ptl_pkg::FRAC_BITS] != '0) ? ptl_pkg::MAXCODE
                   : r_prod[W+ptl_pkg::FRAC_BITS-1:ptl_pkg::FRAC_BITS];
        if (unl) begin
            step = (r_sf != '0) ? ptl_pkg::MAXCODE : '0;
        end else begin
            step = prod_sh;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ptl_pkg::S_IDLE: if (s_axis_tvalid) n_state = ptl_pkg::S_ISSUE;
            ptl_pkg::S_ISSUE: begin
                if (mag != '0) begin
                    n_state = ptl_pkg::S_WAIT;
                end else if (idx_end) begin
                    n_state = r_last ? ptl_pkg::S_MUL : ptl_pkg::S_IDLE;
                end
            end
            ptl_pkg::S_WAIT: begin
                if (w_rsp.done) begin
                    if (idx_end) n_state = r_last ? ptl_pkg::S_MUL : ptl_pkg::S_IDLE;
                    else         n_state = ptl_pkg::S_ISSUE;
                end
            end
            ptl_pkg::S_MUL: n_state = ptl_pkg::S_OUT;
            ptl_pkg::S_OUT: if (out_free) n_state = ptl_pkg::S_IDLE;
            default: n_state = ptl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = r_state == ptl_pkg::S_IDLE;
        o_cfg_ready   = 1'b1;
        w_req.start   = (r_state == ptl_pkg::S_ISSUE) && (mag != '0);
        w_req.acc     = r_idx[0];
        w_req.width   = r_cell[axis];
        w_req.mag     = mag;
    end

    ptl_divsqrt u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ptl_pkg::S_IDLE;
            r_cell[0]     <= ptl_pkg::ONE_FX;
            r_cell[1]     <= ptl_pkg::ONE_FX;
            r_cell[2]     <= ptl_pkg::ONE_FX;
            r_sf          <= ptl_pkg::ONE_FX;
            r_min         <= ptl_pkg::MAXCODE;
            r_idx         <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    ptl_pkg::REG_CELL_X:    r_cell[0] <= i_cfg_data;
                    ptl_pkg::REG_CELL_Y:    r_cell[1] <= i_cfg_data;
                    ptl_pkg::REG_CELL_Z:    r_cell[2] <= i_cfg_data;
                    ptl_pkg::REG_STABILITY: r_sf      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ptl_pkg::S_OUT && out_free) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            unique case (r_state)
                ptl_pkg::S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_vel[0] <= s_axis_tdata[31:0];
                        r_vel[1] <= s_axis_tdata[63:32];
                        r_vel[2] <= s_axis_tdata[95:64];
                        r_acc[0] <= s_axis_tdata[127:96];
                        r_acc[1] <= s_axis_tdata[159:128];
                        r_acc[2] <= s_axis_tdata[191:160];
                        r_last   <= s_axis_tlast;
                        r_idx    <= '0;
                    end
                end
                ptl_pkg::S_ISSUE: begin
                    // advance past a zero component
                    if (mag == '0 && !idx_end) r_idx <= r_idx + 3'd1;
                end
                ptl_pkg::S_WAIT: begin
                    if (w_rsp.done) begin
                        if (w_rsp.limit < r_min) r_min <= w_rsp.limit;
                        if (!idx_end) r_idx <= r_idx + 3'd1;
                    end
                end
                ptl_pkg::S_MUL: r_prod <= 64'(r_min) * 64'(r_sf);
                ptl_pkg::S_OUT: begin
                    if (out_free) begin
                        m_axis_tdata    <= step;
                        m_axis_tuser[0] <= unl;
                        r_min           <= ptl_pkg::MAXCODE;
                    end
                end
                default: ;
            endcase
        end
    end

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_state == ptl_pkg::S_WAIT)
        else $error("limit returned outside wait state");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= ptl_pkg::IDX_LAST)
        else $error("limiter index out of range");

    a_unl_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
        (m_axis_tdata == ptl_pkg::MAXCODE || m_axis_tdata == '0))
        else $error("unlimited result with finite step");

    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ptl_pkg::S_OUT))
        else $error("result loaded outside output state");

endmodule

`default_nettype wire

>>> tb/tb_particle_timestep_limiter.sv
// Testbench for particle_timestep_limiter: drives particles on the slave stream,
// predicts the scaled minimum step per set and checks each master transfer.
// Depends on ptl_pkg and the RTL top level.
`default_nettype none

module tb_particle_timestep_limiter;

    typedef struct packed {
        logic         last;
        logic [191:0] data;
    } t_particle;

    typedef struct packed {
        logic        unl;
        logic [31:0] step;
    } t_step;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    particle_timestep_limiter u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    t_particle   particle_q[$];
    t_step       step_q[$];
    logic [31:0] width_x, width_y, width_z, safety;
    logic [31:0] min_limit;
    int          n_errors;
    int          n_steps;
    longint      cycle;
    logic        tx_quiet, rx_quiet;
    int          hold_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [32:0] magnitude(logic [31:0] raw);
        return raw[31] ? 33'h1_0000_0000 - {1'b0, raw} : {1'b0, raw};
    endfunction

    function automatic logic [31:0] velocity_limit(logic [31:0] w, logic [32:0] mag);
        logic [63:0] q;
        q = ({32'd0, w} << ptl_pkg::FRAC_BITS) / {31'd0, mag};
        return q > 64'hFFFF_FFFF ? ptl_pkg::MAXCODE : q[31:0];
    endfunction

    function automatic logic [31:0] accel_limit(logic [31:0] w, logic [32:0] mag);
        logic [127:0] q;
        logic [63:0]  x, root, bit_v;
        q = ({96'd0, w} << (2 * ptl_pkg::FRAC_BITS + 1)) / {95'd0, mag};
        if (q[127:64] != 0) return ptl_pkg::MAXCODE;
        x = q[63:0];
        root = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v >>= 2;
        while (bit_v != 0) begin
            if (x >= root + bit_v) begin
                x -= root + bit_v;
                root = (root >> 1) + bit_v;
            end else begin
                root >>= 1;
            end
            bit_v >>= 2;
        end
        return root[31:0];
    endfunction

    function automatic void fold(logic [31:0] w, logic [31:0] v, logic [31:0] a);
        logic [32:0] vm, am;
        logic [31:0] t;
        vm = magnitude(v);
        am = magnitude(a);
        if (vm != 0) begin
            t = velocity_limit(w, vm);
            if (t < min_limit) min_limit = t;
        end
        if (am != 0) begin
            t = accel_limit(w, am);
            if (t < min_limit) min_limit = t;
        end
    endfunction

    function automatic void predict_step(t_particle p);
        t_step       r;
        logic [63:0] prod;
        fold(width_x, p.data[31:0], p.data[127:96]);
        fold(width_y, p.data[63:32], p.data[159:128]);
        fold(width_z, p.data[95:64], p.data[191:160]);
        if (!p.last) return;
        r.unl = (min_limit == ptl_pkg::MAXCODE);
        if (r.unl) begin
            r.step = (safety != 0) ? ptl_pkg::MAXCODE : 32'd0;
        end else begin
            prod = ({32'd0, min_limit} * {32'd0, safety}) >> ptl_pkg::FRAC_BITS;
            r.step = prod > 64'hFFFF_FFFF ? ptl_pkg::MAXCODE : prod[31:0];
        end
        step_q.push_back(r);
        min_limit = ptl_pkg::MAXCODE;
    endfunction

    task automatic report(string what);
        $display("mismatch at cycle %0d: %s", cycle, what);
        n_errors++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            ptl_pkg::REG_CELL_X: width_x = val;
            ptl_pkg::REG_CELL_Y: width_y = val;
            ptl_pkg::REG_CELL_Z: width_z = val;
            ptl_pkg::REG_STABILITY: safety = val;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_word(int mode);
        case (mode)
            0: return 32'd0;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(0, 1) ? $urandom_range(1, 1 << 20)
                                          : -$urandom_range(1, 1 << 20);
            default: return $urandom();
        endcase
    endfunction

    function automatic void add_particle(logic [191:0] d, logic last);
        t_particle p;
        p.data = d;
        p.last = last;
        particle_q.push_back(p);
    endfunction

    function automatic void add_random(int n);
        logic [191:0] d;
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < 6; k++)
                d[k*32 +: 32] = rand_word($urandom_range(0, 9));
            add_particle(d, $urandom_range(0, 5) == 0);
        end
        add_particle({6{rand_word(5)}}, 1'b1);
    endfunction

    task automatic drain();
        while (particle_q.size() != 0 || step_q.size() != 0) @(posedge i_clk);
        // a non-last particle may still be folding
        repeat (600) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_step(particle_q.pop_front());
            end
            if ((!s_axis_tvalid || s_axis_tready) ) begin
                if (particle_q.size() != 0 && (tx_quiet || $urandom_range(0, 99) >= 12)
                    && !(s_axis_tvalid && particle_q.size() == 0)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= particle_q[0].data;
                    s_axis_tlast  <= particle_q[0].last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off counter
    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > 4_000_000) begin
            $display("simulation failed");
            $finish;
        end
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (step_q.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    if (m_axis_tdata !== step_q[0].step)
                        report($sformatf("step %h expected %h", m_axis_tdata, step_q[0].step));
                    if (m_axis_tuser[0] !== step_q[0].unl)
                        report($sformatf("unlimited %b expected %b", m_axis_tuser[0],
                                         step_q[0].unl));
                    void'(step_q.pop_front());
                    n_steps++;
                end
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= rx_quiet || $urandom_range(0, 99) >= 12;
            end
        end
    end

    initial begin
        logic [191:0] d;
        n_errors = 0; n_steps = 0; cycle = 0; hold_left = 0;
        tx_quiet = 0; rx_quiet = 0;
        width_x = ptl_pkg::ONE_FX; width_y = ptl_pkg::ONE_FX;
        width_z = ptl_pkg::ONE_FX; safety = ptl_pkg::ONE_FX;
        min_limit = ptl_pkg::MAXCODE;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = ptl_pkg::REG_CELL_X; i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zeros, extremes, most negative, each axis alone
        add_particle('0, 1'b1);
        add_particle({6{32'h8000_0000}}, 1'b1);
        add_particle({6{32'h7FFF_FFFF}}, 1'b1);
        add_particle({6{32'h0000_0001}}, 1'b1);
        add_particle({6{32'hFFFF_FFFF}}, 1'b0);
        add_particle({6{32'h0001_0000}}, 1'b1);
        for (int k = 0; k < 6; k++) begin
            d = '0;
            d[k*32 +: 32] = 32'hFFFE_0000;
            add_particle(d, 1'b1);
        end
        drain();

        // zero widths and zero safety factor
        write_reg(ptl_pkg::REG_CELL_X, 32'd0);
        write_reg(ptl_pkg::REG_CELL_Y, 32'd0);
        write_reg(ptl_pkg::REG_CELL_Z, 32'd0);
        write_reg(ptl_pkg::REG_STABILITY, 32'd0);
        add_particle('0, 1'b1);
        add_particle({6{32'h0003_0000}}, 1'b1);
        drain();

        write_reg(ptl_pkg::REG_CELL_X, 32'hFFFF_FFFF);
        write_reg(ptl_pkg::REG_CELL_Y, 32'hFFFF_FFFF);
        write_reg(ptl_pkg::REG_CELL_Z, 32'hFFFF_FFFF);
        write_reg(ptl_pkg::REG_STABILITY, 32'hFFFF_FFFF);
        add_particle({6{32'h0000_0001}}, 1'b1);
        add_particle({6{32'h8000_0000}}, 1'b1);
        add_random(60);
        drain();

        // long receiver hold-off while particles keep coming
        hold_left = 20000;
        write_reg(ptl_pkg::REG_CELL_X, ptl_pkg::ONE_FX);
        write_reg(ptl_pkg::REG_CELL_Y, 32'h0000_8000);
        write_reg(ptl_pkg::REG_CELL_Z, 32'h0004_0000);
        write_reg(ptl_pkg::REG_STABILITY, 32'h0000_C000);
        add_random(200);
        drain();

        // no idling stretch
        tx_quiet = 1; rx_quiet = 1;
        add_random(150);
        drain();
        tx_quiet = 0; rx_quiet = 0;

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(ptl_pkg::REG_CELL_X, $urandom());
            write_reg(ptl_pkg::REG_CELL_Y, $urandom_range(0, 1 << 20));
            write_reg(ptl_pkg::REG_CELL_Z, $urandom());
            write_reg(ptl_pkg::REG_STABILITY, $urandom_range(0, 1 << 18));
            add_random(130);
            drain();
        end

        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

`default_nettype wire

>>> filelist.f
rtl/ptl_pkg.sv
rtl/ptl_divsqrt.sv
rtl/particle_timestep_limiter.sv
tb/tb_particle_timestep_limiter.sv
